/* hw/rtl/cpi_pkg.sv */
// Shared types and constants for the color palette indexer.
package cpi_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 256;

    localparam int KEY_W   = 24;
    localparam int CODE_W  = 16;
    localparam int ENTRY_W = KEY_W + CODE_W;

    // Request types.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_PIXEL = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MISSING   = 2'd1;
    localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] entry_code;
    } pix_req_t;

    typedef struct packed {
        logic [15:0] code;
        logic [1:0]  status;
        logic        new_color;
    } pix_res_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } ctrl_state_t;

endpackage

/* hw/rtl/cpi_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module cpi_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/cpi_ctrl.sv */
// Request sequencer: table scan, decision and write-back for the palette indexer.
module cpi_ctrl #(
    parameter int unsigned TABLE_ENTRIES = cpi_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                fixed_mode,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cpi_pkg::pix_req_t                   s_req,
    output logic                                res_valid,
    input  logic                                res_ready,
    output cpi_pkg::pix_res_t                   res,
    output logic                                ram_wr_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0]    ram_wr_addr,
    output logic [cpi_pkg::ENTRY_W-1:0]         ram_wr_data,
    output logic                                ram_rd_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0]    ram_rd_addr,
    input  logic [cpi_pkg::ENTRY_W-1:0]         ram_rd_data
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W  = cpi_pkg::KEY_W;
    localparam int CODE_W = cpi_pkg::CODE_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    cpi_pkg::ctrl_state_t state_reg, state_next;
    cpi_pkg::pix_req_t    req_reg, req_next;
    cpi_pkg::pix_res_t    res_reg, res_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [CODE_W-1:0]    hit_code_reg, hit_code_next;
    logic                 dup_reg, dup_next;

    logic [KEY_W-1:0]  key_in;
    logic [KEY_W-1:0]  rd_key;
    logic [CODE_W-1:0] rd_code;
    logic [CODE_W-1:0] auto_code;
    logic              key_eq;
    logic              key_match;
    logic              code_match;
    logic              issue_more;
    logic              full;

    assign key_in     = {req_reg.red, req_reg.green, req_reg.blue};
    assign rd_key     = ram_rd_data[CODE_W +: KEY_W];
    assign rd_code    = ram_rd_data[CODE_W-1:0];
    assign key_eq     = (rd_key == key_in);
    assign key_match  = pend_reg && key_eq;
    // A code held by the entry of the same color does not count as taken.
    assign code_match = pend_reg && !key_eq && (rd_code == req_reg.entry_code);
    assign issue_more = (issue_reg < count_reg);
    assign full       = (count_reg == FULL_COUNT);
    assign auto_code  = CODE_W'(count_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cpi_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (s_req.req_type == cpi_pkg::REQ_LOAD ||
                        s_req.req_type == cpi_pkg::REQ_PIXEL) begin
                        state_next = cpi_pkg::S_SCAN;
                    end else begin
                        state_next = cpi_pkg::S_DONE;
                    end
                end
            end
            cpi_pkg::S_SCAN: begin
                if (!issue_more && !pend_reg) begin
                    state_next = cpi_pkg::S_DECIDE;
                end
            end
            cpi_pkg::S_DECIDE: begin
                state_next = cpi_pkg::S_DONE;
            end
            cpi_pkg::S_DONE: begin
                if (res_ready) begin
                    state_next = cpi_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cpi_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        req_next      = req_reg;
        res_next      = res_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        cmp_idx_next  = cmp_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_code_next = hit_code_reg;
        dup_next      = dup_reg;
        s_ready       = 1'b0;
        res_valid     = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = hit_idx_reg;
        ram_wr_data   = {key_in, req_reg.entry_code};
        ram_rd_en     = 1'b0;
        ram_rd_addr   = issue_reg[IDX_W-1:0];
        unique case (state_reg)
            cpi_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next   = s_req;
                    res_next   = '0;
                    issue_next = '0;
                    hit_next   = 1'b0;
                    dup_next   = 1'b0;
                    if (s_req.req_type == cpi_pkg::REQ_CLEAR) begin
                        count_next = '0;
                    end
                end
            end
            cpi_pkg::S_SCAN: begin
                pend_next = issue_more;
                if (issue_more) begin
                    ram_rd_en    = 1'b1;
                    issue_next   = CNT_W'(issue_reg + 1'b1);
                    cmp_idx_next = issue_reg[IDX_W-1:0];
                end
                if (key_match) begin
                    hit_next      = 1'b1;
                    hit_idx_next  = cmp_idx_reg;
                    hit_code_next = rd_code;
                end
                if (code_match) begin
                    dup_next = 1'b1;
                end
            end
            cpi_pkg::S_DECIDE: begin
                if (req_reg.req_type == cpi_pkg::REQ_LOAD) begin
                    priority if (dup_reg) begin
                        res_next.status = cpi_pkg::STATUS_DUPLICATE;
                    end else if (hit_reg) begin
                        ram_wr_en     = 1'b1;
                        res_next.code = req_reg.entry_code;
                    end else if (full) begin
                        res_next.status = cpi_pkg::STATUS_FULL;
                    end else begin
                        ram_wr_en     = 1'b1;
                        ram_wr_addr   = count_reg[IDX_W-1:0];
                        count_next    = CNT_W'(count_reg + 1'b1);
                        res_next.code = req_reg.entry_code;
                    end
                end else begin
                    priority if (hit_reg) begin
                        res_next.code = hit_code_reg;
                    end else if (fixed_mode) begin
                        res_next.status = cpi_pkg::STATUS_MISSING;
                    end else if (full) begin
                        res_next.status = cpi_pkg::STATUS_FULL;
                    end else begin
                        ram_wr_en          = 1'b1;
                        ram_wr_addr        = count_reg[IDX_W-1:0];
                        ram_wr_data        = {key_in, auto_code};
                        count_next         = CNT_W'(count_reg + 1'b1);
                        res_next.code      = auto_code;
                        res_next.new_color = 1'b1;
                    end
                end
            end
            cpi_pkg::S_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cpi_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        req_reg      <= req_next;
        res_reg      <= res_next;
        issue_reg    <= issue_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_code_reg <= hit_code_next;
        dup_reg      <= dup_next;
    end

    assign res = res_reg;

    // Colors are unique among filled entries, so a scan finds at most one match.
    a_hit_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cpi_pkg::S_SCAN && key_match) |-> !hit_reg)
        else $error("second key match during one scan");

    // The fill count moves by at most one entry per step outside a clear.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != cpi_pkg::S_IDLE) |=>
        (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1))
        else $error("fill count jumped");

    // No read may still be in flight once the scan has been left.
    a_no_stray_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != cpi_pkg::S_SCAN) |-> !pend_reg)
        else $error("read data pending outside scan");

    // Writes land on a filled entry or on the first free one.
    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (CNT_W'(ram_wr_addr) < count_reg ||
                       (CNT_W'(ram_wr_addr) == count_reg && !full)))
        else $error("table write outside filled region");

endmodule

/* hw/rtl/color_palette_indexer.sv */
// Top level of the color palette indexer: config register, table RAM and result register.
//
// The block maps 24-bit pixel colors to 16-bit palette codes. Requests arrive on the
// s_ channel (valid/ready, payload s_data): clear the table, load a color-to-code
// entry, or map a pixel. Each request returns exactly one result on the m_ channel
// (m_valid/m_ready, payload m_data) with a code, a status and a new-color flag.
// The cfg_ channel writes the fixed_mode register; it is always ready and must only
// be written while no request is in flight.
// The table is a single RAM of color/code pairs filled from entry zero upward. A load
// or pixel request scans every filled entry through the RAM read port, one entry per
// cycle, then decides and writes back at most one entry; a clear or an unused request
// type skips the scan. The next request is taken in the cycle after the result is
// registered, so requests are handled one at a time and the read port scan sets the
// throughput.
// Reset empties the table at once by zeroing the fill count; there is no clearing pass,
// and fixed_mode returns to zero (auto mode).
// A finished result sits in an output register, so a new request is taken while the
// receiver stalls; the following result then waits in the sequencer until that
// register is drained.
module color_palette_indexer #(
    parameter int unsigned TABLE_ENTRIES = cpi_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cpi_pkg::pix_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cpi_pkg::pix_res_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic                        fixed_mode_reg;
    logic                        m_valid_reg;
    cpi_pkg::pix_res_t           m_data_reg;

    logic                        res_valid;
    logic                        res_ready;
    cpi_pkg::pix_res_t           res;

    logic                        ram_wr_en;
    logic [IDX_W-1:0]            ram_wr_addr;
    logic [cpi_pkg::ENTRY_W-1:0] ram_wr_data;
    logic                        ram_rd_en;
    logic [IDX_W-1:0]            ram_rd_addr;
    logic [cpi_pkg::ENTRY_W-1:0] ram_rd_data;

    // The mode register accepts a write in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fixed_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            fixed_mode_reg <= cfg_data;
        end
    end

    // The output register takes a new result when empty or when drained this cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    cpi_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fixed_mode  (fixed_mode_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    cpi_ram #(
        .WIDTH (cpi_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

/* tb/sv/palette_checker.sv */
// Result checker for the color palette indexer: mirrors the palette table and compares results.
`timescale 1ns / 100ps

module palette_checker #(
    parameter int unsigned TABLE_ENTRIES = cpi_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  cpi_pkg::pix_req_t s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  cpi_pkg::pix_res_t m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_data,
    output int                mismatch_count,
    output int                results_due
);

    localparam int KEY_W  = cpi_pkg::KEY_W;
    localparam int CODE_W = cpi_pkg::CODE_W;

    // Mirror of the palette: entries below fill_count are the valid ones.
    logic [KEY_W-1:0]  palette_color [TABLE_ENTRIES];
    logic [CODE_W-1:0] palette_code  [TABLE_ENTRIES];
    int unsigned       fill_count;
    logic              fixed_mode;

    cpi_pkg::pix_res_t palette_results_due [$];

    function automatic int find_color(input logic [KEY_W-1:0] color);
        int i;
        for (i = 0; i < int'(fill_count); i++) begin
            if (palette_color[i] == color) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void append_color(input logic [KEY_W-1:0] color,
                                         input logic [CODE_W-1:0] code);
        palette_color[fill_count] = color;
        palette_code[fill_count]  = code;
        fill_count++;
    endfunction

    // Works out the result of one request and updates the mirrored table.
    function automatic cpi_pkg::pix_res_t predict_palette_result(input cpi_pkg::pix_req_t req);
        cpi_pkg::pix_res_t res;
        logic [KEY_W-1:0]  color;
        int                hit;
        logic              taken;
        int                i;
        res   = '0;
        color = {req.red, req.green, req.blue};
        case (req.req_type)
            cpi_pkg::REQ_CLEAR: begin
                fill_count = 0;
            end
            cpi_pkg::REQ_LOAD: begin
                hit   = find_color(color);
                taken = 1'b0;
                for (i = 0; i < int'(fill_count); i++) begin
                    if (i != hit && palette_code[i] == req.entry_code) begin
                        taken = 1'b1;
                    end
                end
                if (taken) begin
                    res.status = cpi_pkg::STATUS_DUPLICATE;
                end else if (hit >= 0) begin
                    palette_code[hit] = req.entry_code;
                    res.code          = req.entry_code;
                end else if (fill_count >= TABLE_ENTRIES) begin
                    res.status = cpi_pkg::STATUS_FULL;
                end else begin
                    append_color(color, req.entry_code);
                    res.code = req.entry_code;
                end
            end
            cpi_pkg::REQ_PIXEL: begin
                hit = find_color(color);
                if (hit >= 0) begin
                    res.code = palette_code[hit];
                end else if (fixed_mode) begin
                    res.status = cpi_pkg::STATUS_MISSING;
                end else if (fill_count >= TABLE_ENTRIES) begin
                    res.status = cpi_pkg::STATUS_FULL;
                end else begin
                    res.code      = CODE_W'(fill_count);
                    res.new_color = 1'b1;
                    append_color(color, res.code);
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: palette result mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        cpi_pkg::pix_res_t want;
        if (!aresetn) begin
            fill_count     = 0;
            fixed_mode     = 1'b0;
            mismatch_count = 0;
            palette_results_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                fixed_mode = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (palette_results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result code %h status %0d new %0d",
                                              m_data.code, m_data.status, m_data.new_color));
                end else begin
                    want = palette_results_due.pop_front();
                    if (m_data.code !== want.code || m_data.status !== want.status ||
                        m_data.new_color !== want.new_color) begin
                        report_mismatch($sformatf(
                            "code %h/%h status %0d/%0d new %0d/%0d (got/expected)",
                            m_data.code, want.code, m_data.status, want.status,
                            m_data.new_color, want.new_color));
                    end
                end
            end
            if (s_valid && s_ready) begin
                palette_results_due.push_back(predict_palette_result(s_data));
            end
        end
        results_due <= palette_results_due.size();
    end

endmodule

/* tb/sv/color_palette_indexer_tb.sv */
// Top-level testbench for the color palette indexer: stimulus, stalls and the final verdict.
`timescale 1ns / 100ps

module color_palette_indexer_tb;

    localparam int unsigned TBL_DEPTH = cpi_pkg::TABLE_ENTRIES_DEF;
    localparam int          KEY_W     = cpi_pkg::KEY_W;
    localparam int          CODE_W    = cpi_pkg::CODE_W;

    // The package names no constant for the fourth request type, which the block ignores.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // A long receiver stall, well beyond what the block can buffer, so the input backs up.
    localparam int LONG_HOLD_CYCLES = 300;

    // A full-table scan is the longest a request can take, so after the last result
    // we keep watching for about that long to catch any stray output.
    localparam int DRAIN_CYCLES = TBL_DEPTH + 40;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    cpi_pkg::pix_req_t s_data;
    logic              m_valid;
    logic              m_ready;
    cpi_pkg::pix_res_t m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;

    int                mismatch_count;
    int                results_due;

    // Set by the stimulus process: one long receiver stall, and a calm tail with no idling.
    logic              long_hold_go = 1'b0;
    logic              calm         = 1'b0;

    // Colors and codes already sent, so random requests can hit the table on purpose.
    logic [KEY_W-1:0]  seen_colors [$];
    logic [CODE_W-1:0] used_codes  [$];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    color_palette_indexer #(
        .TABLE_ENTRIES(TBL_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    palette_checker #(
        .TABLE_ENTRIES(TBL_DEPTH)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .results_due   (results_due)
    );

    // Offers one request and returns at the edge where it is accepted. Before it, the
    // sender may idle for a random burst; otherwise valid simply stays high from the
    // previous request, which keeps back-to-back traffic possible.
    task automatic send_request(input logic [1:0] kind, input logic [KEY_W-1:0] color,
                                input logic [CODE_W-1:0] code);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_data.req_type   <= kind;
        s_data.red        <= color[23:16];
        s_data.green      <= color[15:8];
        s_data.blue       <= color[7:0];
        s_data.entry_code <= code;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering requests and waits until every predicted result has come back.
    // The checker updates its count at the clock edge, so we always see a settled value.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
    endtask

    // The mode register may only change while no request is in flight.
    task automatic write_mode(input logic fixed);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= fixed;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_seen_color();
        if (seen_colors.size() == 0) begin
            return KEY_W'($urandom);
        end
        return seen_colors[$urandom_range(0, seen_colors.size() - 1)];
    endfunction

    // Mostly a code that is likely already in the table, to provoke duplicate rejects.
    // Small values collide with the indices that auto mode hands out.
    function automatic logic [CODE_W-1:0] pick_clashing_code();
        if (used_codes.size() != 0 && $urandom_range(0, 1) == 0) begin
            return used_codes[$urandom_range(0, used_codes.size() - 1)];
        end
        return CODE_W'($urandom_range(0, 300));
    endfunction

    // Receiver: random ready bursts, one long hold on request, and always ready once
    // the run has gone calm. Every stall length is counted here in clock cycles.
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (long_hold_go && !hold_done) begin
                hold_done = 1'b1;
                m_ready  <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Stimulus and verdict.
    initial begin
        int                n;
        int                pick;
        logic [KEY_W-1:0]  color;
        logic [CODE_W-1:0] code;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, in auto mode straight out of reset. First two new colors take
        // indices 0 and 1, then a repeat must hit without inserting.
        send_request(cpi_pkg::REQ_PIXEL, 24'h000000, 16'h0000);
        send_request(cpi_pkg::REQ_PIXEL, 24'hFFFFFF, 16'hFFFF);
        send_request(cpi_pkg::REQ_PIXEL, 24'h000000, 16'h0000);
        // A load of a fresh color appends it; a load whose code another color holds is
        // a duplicate; reloading a color with its own code or a free code replaces it.
        send_request(cpi_pkg::REQ_LOAD, 24'h123456, 16'hFFFF);
        send_request(cpi_pkg::REQ_LOAD, 24'hABCDEF, 16'h0001);
        send_request(cpi_pkg::REQ_LOAD, 24'hFFFFFF, 16'h0001);
        send_request(cpi_pkg::REQ_LOAD, 24'hFFFFFF, 16'h0005);
        send_request(cpi_pkg::REQ_LOAD, 24'h000000, 16'hFFFF);
        // Auto insertion does not look at loaded codes: the second new pixel below gets
        // index 5, which white already holds as a loaded code.
        send_request(cpi_pkg::REQ_PIXEL, 24'h0F0F0F, 16'h0000);
        send_request(cpi_pkg::REQ_LOAD, 24'h222222, 16'h0004);
        send_request(cpi_pkg::REQ_PIXEL, 24'h333333, 16'hFFFF);
        // The unused request type changes nothing and answers with an empty result.
        send_request(REQ_UNUSED, 24'hA5A5A5, 16'h5A5A);
        send_request(cpi_pkg::REQ_PIXEL, 24'hFFFFFF, 16'h0000);

        // Fixed mode: hits still resolve, misses report a missing color, loads work.
        write_mode(1'b1);
        send_request(cpi_pkg::REQ_PIXEL, 24'h000000, 16'h0000);
        send_request(cpi_pkg::REQ_PIXEL, 24'h0A0B0C, 16'h0000);
        send_request(cpi_pkg::REQ_LOAD, 24'h0A0B0C, 16'h1234);
        send_request(cpi_pkg::REQ_PIXEL, 24'h0A0B0C, 16'h0000);
        send_request(cpi_pkg::REQ_CLEAR, 24'hFFFFFF, 16'hFFFF);
        send_request(cpi_pkg::REQ_PIXEL, 24'h000000, 16'h0000);
        send_request(cpi_pkg::REQ_LOAD, 24'h800001, 16'h0000);
        send_request(cpi_pkg::REQ_PIXEL, 24'h800001, 16'hFFFF);
        write_mode(1'b0);
        send_request(cpi_pkg::REQ_PIXEL, 24'h7F7F7F, 16'h0000);
        send_request(cpi_pkg::REQ_CLEAR, 24'h000000, 16'h0000);

        // Auto mode, filling the table well past its capacity. Once it is full, new
        // pixels and loads of new colors must report a full table while hits go on.
        write_mode(1'b0);
        for (n = 0; n < 330; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                color = KEY_W'($urandom);
                seen_colors.push_back(color);
                send_request(cpi_pkg::REQ_PIXEL, color, CODE_W'($urandom));
            end else if (pick < 88) begin
                color = KEY_W'($urandom);
                code  = CODE_W'($urandom);
                seen_colors.push_back(color);
                used_codes.push_back(code);
                send_request(cpi_pkg::REQ_LOAD, color, code);
            end else if (pick < 95) begin
                send_request(cpi_pkg::REQ_PIXEL, pick_seen_color(), CODE_W'($urandom));
            end else if (pick < 99) begin
                send_request(cpi_pkg::REQ_LOAD, pick_seen_color(), pick_clashing_code());
            end else begin
                send_request(REQ_UNUSED, KEY_W'($urandom), CODE_W'($urandom));
            end
        end

        // Fixed mode with a freshly loaded table of moderate size.
        write_mode(1'b1);
        send_request(cpi_pkg::REQ_CLEAR, KEY_W'($urandom), CODE_W'($urandom));
        seen_colors.delete();
        used_codes.delete();
        for (n = 0; n < 40; n++) begin
            color = KEY_W'($urandom);
            code  = ($urandom_range(0, 4) == 0) ? pick_clashing_code() : CODE_W'($urandom);
            seen_colors.push_back(color);
            used_codes.push_back(code);
            send_request(cpi_pkg::REQ_LOAD, color, code);
        end
        for (n = 0; n < 140; n++) begin
            // While the table is small the block turns requests around quickly, so a
            // long receiver stall here makes it fill up and hold off the sender.
            if (n == 20) begin
                long_hold_go <= 1'b1;
            end
            // The sender also pauses once until everything outstanding has returned.
            if (n == 80) begin
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_request(cpi_pkg::REQ_PIXEL, pick_seen_color(), CODE_W'($urandom));
            end else if (pick < 80) begin
                send_request(cpi_pkg::REQ_PIXEL, KEY_W'($urandom), CODE_W'($urandom));
            end else if (pick < 92) begin
                code = ($urandom_range(0, 1) == 0) ? pick_clashing_code() : CODE_W'($urandom);
                used_codes.push_back(code);
                send_request(cpi_pkg::REQ_LOAD, pick_seen_color(), code);
            end else if (pick < 97) begin
                color = KEY_W'($urandom);
                code  = CODE_W'($urandom);
                seen_colors.push_back(color);
                used_codes.push_back(code);
                send_request(cpi_pkg::REQ_LOAD, color, code);
            end else begin
                send_request(REQ_UNUSED, KEY_W'($urandom), CODE_W'($urandom));
            end
        end

        // Auto mode on a small palette with occasional clears, so colors that were
        // indexed before come back as new ones. The tail runs with no idling at all.
        write_mode(1'b0);
        send_request(cpi_pkg::REQ_CLEAR, KEY_W'($urandom), CODE_W'($urandom));
        seen_colors.delete();
        used_codes.delete();
        for (n = 0; n < 140; n++) begin
            if (n == 80) begin
                calm <= 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25 && seen_colors.size() < 24) begin
                color = KEY_W'($urandom);
                seen_colors.push_back(color);
                send_request(cpi_pkg::REQ_PIXEL, color, CODE_W'($urandom));
            end else if (pick < 85) begin
                send_request(cpi_pkg::REQ_PIXEL, pick_seen_color(), CODE_W'($urandom));
            end else if (pick < 93) begin
                send_request(cpi_pkg::REQ_LOAD, pick_seen_color(), pick_clashing_code());
            end else if (pick < 98) begin
                send_request(cpi_pkg::REQ_CLEAR, KEY_W'($urandom), CODE_W'($urandom));
            end else begin
                send_request(REQ_UNUSED, KEY_W'($urandom), CODE_W'($urandom));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Safety net: several times the slowest correct run, where every request scans a
    // full table and both sides stall as long as they ever do.
    initial begin
        #(10_000_000);
        $display("Timeout: simulation did not finish in time");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* color_palette_indexer.f */
hw/rtl/cpi_pkg.sv
hw/rtl/cpi_ram.sv
hw/rtl/cpi_ctrl.sv
hw/rtl/color_palette_indexer.sv
tb/sv/palette_checker.sv
tb/sv/color_palette_indexer_tb.sv
